>>> hdl/urb_pkg.sv
// Shared types and constants of the UART register block: request and response
// payloads, item kinds, register offsets and interrupt identifiers.
// No dependencies.
`default_nettype none

package urb_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_RX    = 2'd2,
    MODE_TX    = 2'd3
  } mode_e;

  localparam logic [2:0] ADDR_RBR_THR = 3'd0;
  localparam logic [2:0] ADDR_IER     = 3'd1;
  localparam logic [2:0] ADDR_IIR_FCR = 3'd2;
  localparam logic [2:0] ADDR_LCR     = 3'd3;
  localparam logic [2:0] ADDR_MCR     = 3'd4;
  localparam logic [2:0] ADDR_LSR     = 3'd5;
  localparam logic [2:0] ADDR_MSR     = 3'd6;
  localparam logic [2:0] ADDR_SCR     = 3'd7;

  localparam logic [2:0] INT_ID_RDA   = 3'd2;
  localparam logic [2:0] INT_ID_THRE  = 3'd1;
  localparam logic [2:0] INT_ID_MODEM = 3'd0;

  // FIFO control bits that are kept when the FIFOs are enabled.
  localparam logic [7:0] FCR_KEEP_MASK = 8'hC9;
  // IIR bits 7:6 report enabled FIFOs.
  localparam logic [1:0] IIR_FIFO_ON   = 2'b11;
  // Character length is this plus LCR bits 1:0.
  localparam logic [3:0] CHAR_BITS_MIN = 4'd5;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  reg_addr;
    logic [7:0]  write_data;
    logic [7:0]  rx_byte;
    logic        dcd_in;
    logic        ri_in;
    logic        dsr_in;
    logic        cts_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_pending;
    logic [2:0]  int_id;
    logic        rx_full;
    logic        dtr_out;
    logic        rts_out;
    logic [15:0] baud_divisor;
    logic [3:0]  char_bits;
    logic        parity_enable;
    logic        parity_odd;
  } rsp_t;

endpackage

`default_nettype wire

>>> hdl/urb_if.sv
// Valid/ready channel interfaces for requests and responses of the UART block.
// Depends on urb_pkg for the payload types.
`default_nettype none

interface urb_req_if
  import urb_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface urb_rsp_if
  import urb_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/uart_register_block_with_fifos.sv
// Top level of the 16550-style UART register block with receive and transmit FIFOs.
// Depends on urb_pkg and the channel interfaces in urb_if.sv.
`default_nettype none

// The block takes one request per clock: a bus read, a bus write, a received
// character or a free transmit slot. Its response, which shows the register
// state after that request, appears in the output register on the next cycle.
// A new request is taken whenever the output register is empty or its response
// is being taken in the same cycle, so the block runs at one request per cycle
// while its responses are taken. Both FIFOs live in small memories of RX_DEPTH and
// TX_DEPTH bytes; the popped byte goes from the memory straight into the output
// register. FIFO contents are undefined after reset and need no clearing pass.
module uart_register_block_with_fifos
  import urb_pkg::*;
#(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  urb_req_if.sink    req_i,
  urb_rsp_if.source  rsp_o
);

  localparam int RX_PW = $clog2(2 * RX_DEPTH);
  localparam int RX_SW = $clog2(RX_DEPTH);
  localparam int TX_PW = $clog2(2 * TX_DEPTH);
  localparam int TX_SW = $clog2(TX_DEPTH);

  localparam logic [RX_PW-1:0] RX_D    = RX_PW'(RX_DEPTH);
  localparam logic [RX_PW-1:0] RX_TWO  = RX_PW'(2 * RX_DEPTH);
  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(2 * RX_DEPTH - 1);
  localparam logic [TX_PW-1:0] TX_D    = TX_PW'(TX_DEPTH);
  localparam logic [TX_PW-1:0] TX_TWO  = TX_PW'(2 * TX_DEPTH);
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(2 * TX_DEPTH - 1);

  typedef struct packed {
    logic       pending;
    logic [2:0] id;
  } irq_t;

  // Line status error bits are never set, so the line status source never fires.
  function automatic irq_t irq_eval(logic [3:0] ier, logic dr, logic thre, logic [3:0] dlt);
    irq_t r;
    r.pending = 1'b1;
    if (ier[0] && dr) begin
      r.id = INT_ID_RDA;
    end else if (ier[1] && thre) begin
      r.id = INT_ID_THRE;
    end else if (ier[3] && (dlt != 4'd0)) begin
      r.id = INT_ID_MODEM;
    end else begin
      r.pending = 1'b0;
      r.id      = INT_ID_MODEM;
    end
    return r;
  endfunction

  // State registers.
  logic [RX_PW-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [TX_PW-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic [7:0] lcr_q, lcr_d;
  logic [4:0] mcr_q, mcr_d;
  logic [3:0] ier_q, ier_d;
  logic [7:0] fcr_q, fcr_d;
  logic [3:0] lvl_q, lvl_d;
  logic [3:0] dlt_q, dlt_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic [7:0] scr_q, scr_d;
  logic       out_valid_q;
  rsp_t       rsp_q, rsp_d;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic in_accept;
  logic rx_push, rx_pop, tx_push, tx_pop, rx_clr, tx_clr;
  logic [3:0] lvl_now, dlt_s;
  logic [7:0] rd_data, lsr_pre;
  irq_t irq_pre, irq_post;
  logic dlab;

  logic [RX_PW-1:0] rx_cnt_q, rx_cnt_d;
  logic [TX_PW-1:0] tx_cnt_q, tx_cnt_d;
  logic rx_empty_q, rx_full_q, tx_empty_q, tx_full_q;
  logic rx_empty_d, rx_full_d, tx_full_d;
  logic [RX_SW-1:0] rx_wslot, rx_rslot;
  logic [TX_SW-1:0] tx_wslot, tx_rslot;

  assign req_i.ready   = !out_valid_q || rsp_o.ready;
  assign in_accept     = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // Pointers run modulo twice the depth so that full and empty differ.
  assign rx_cnt_q = (rx_wp_q >= rx_rp_q) ? (rx_wp_q - rx_rp_q) : (rx_wp_q - rx_rp_q + RX_TWO);
  assign tx_cnt_q = (tx_wp_q >= tx_rp_q) ? (tx_wp_q - tx_rp_q) : (tx_wp_q - tx_rp_q + TX_TWO);
  assign rx_cnt_d = (rx_wp_d >= rx_rp_d) ? (rx_wp_d - rx_rp_d) : (rx_wp_d - rx_rp_d + RX_TWO);
  assign tx_cnt_d = (tx_wp_d >= tx_rp_d) ? (tx_wp_d - tx_rp_d) : (tx_wp_d - tx_rp_d + TX_TWO);

  assign rx_empty_q = (rx_cnt_q == '0);
  assign rx_full_q  = (rx_cnt_q == RX_D);
  assign tx_empty_q = (tx_cnt_q == '0);
  assign tx_full_q  = (tx_cnt_q == TX_D);
  assign rx_empty_d = (rx_cnt_d == '0);
  assign rx_full_d  = (rx_cnt_d == RX_D);
  assign tx_full_d  = (tx_cnt_d == TX_D);

  assign rx_wslot = (rx_wp_q >= RX_D) ? RX_SW'(rx_wp_q - RX_D) : RX_SW'(rx_wp_q);
  assign rx_rslot = (rx_rp_q >= RX_D) ? RX_SW'(rx_rp_q - RX_D) : RX_SW'(rx_rp_q);
  assign tx_wslot = (tx_wp_q >= TX_D) ? TX_SW'(tx_wp_q - TX_D) : TX_SW'(tx_wp_q);
  assign tx_rslot = (tx_rp_q >= TX_D) ? TX_SW'(tx_rp_q - TX_D) : TX_SW'(tx_rp_q);

  // Line status as seen before the request: TEMT, THRE and DR.
  assign lsr_pre = {1'b0, tx_empty_q, !tx_full_q, 4'b0000, !rx_empty_q};
  assign dlab    = lcr_q[7];

  assign lvl_now = {req_i.payload.dcd_in, req_i.payload.ri_in,
                    req_i.payload.dsr_in, req_i.payload.cts_in};
  // Ring indicator flags only its trailing edge.
  assign dlt_s   = dlt_q | ((lvl_now ^ lvl_q) & 4'b1011)
                 | {1'b0, lvl_q[2] & !lvl_now[2], 2'b00};

  assign irq_pre  = irq_eval(ier_q, !rx_empty_q, !tx_full_q, dlt_s);
  assign irq_post = irq_eval(ier_d, !rx_empty_d, !tx_full_d, dlt_d);

  always_comb begin
    lcr_d   = lcr_q;
    mcr_d   = mcr_q;
    ier_d   = ier_q;
    fcr_d   = fcr_q;
    dll_d   = dll_q;
    dlm_d   = dlm_q;
    scr_d   = scr_q;
    lvl_d   = lvl_now;
    dlt_d   = dlt_s;
    rd_data = 8'h00;
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    rx_clr  = 1'b0;
    tx_clr  = 1'b0;
    case (req_i.payload.mode)
      MODE_READ: begin
        case (req_i.payload.reg_addr)
          ADDR_RBR_THR: begin
            if (dlab) begin
              rd_data = dll_q;
            end else begin
              rx_pop = !rx_empty_q;
            end
          end
          ADDR_IER:     rd_data = dlab ? dlm_q : {4'b0000, ier_q};
          ADDR_IIR_FCR: rd_data = {(fcr_q[0] ? IIR_FIFO_ON : 2'b00), 2'b00,
                                   irq_pre.id, !irq_pre.pending};
          ADDR_LCR:     rd_data = lcr_q;
          ADDR_MCR:     rd_data = {3'b000, mcr_q};
          ADDR_LSR:     rd_data = lsr_pre;
          ADDR_MSR: begin
            rd_data = {lvl_now, dlt_s};
            dlt_d   = 4'b0000;
          end
          default:      rd_data = scr_q;
        endcase
      end
      MODE_WRITE: begin
        case (req_i.payload.reg_addr)
          ADDR_RBR_THR: begin
            if (dlab) begin
              dll_d = req_i.payload.write_data;
            end else begin
              tx_push = !tx_full_q;
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              dlm_d = req_i.payload.write_data;
            end else begin
              ier_d = req_i.payload.write_data[3:0];
            end
          end
          ADDR_IIR_FCR: begin
            // Toggling the enable empties both FIFOs.
            if (req_i.payload.write_data[0] != fcr_q[0]) begin
              rx_clr = 1'b1;
              tx_clr = 1'b1;
            end
            if (!req_i.payload.write_data[0]) begin
              fcr_d = 8'h00;
            end else begin
              if (req_i.payload.write_data[1]) rx_clr = 1'b1;
              if (req_i.payload.write_data[2]) tx_clr = 1'b1;
              fcr_d = req_i.payload.write_data & FCR_KEEP_MASK;
            end
          end
          ADDR_LCR: lcr_d = req_i.payload.write_data;
          ADDR_MCR: mcr_d = req_i.payload.write_data[4:0];
          ADDR_SCR: scr_d = req_i.payload.write_data;
          default: ;
        endcase
      end
      MODE_RX: rx_push = !rx_full_q;
      default: tx_pop = !tx_empty_q;
    endcase

    rx_wp_d = rx_wp_q;
    rx_rp_d = rx_rp_q;
    tx_wp_d = tx_wp_q;
    tx_rp_d = tx_rp_q;
    if (rx_push) rx_wp_d = (rx_wp_q == RX_LAST) ? '0 : rx_wp_q + RX_PW'(1);
    if (rx_pop)  rx_rp_d = (rx_rp_q == RX_LAST) ? '0 : rx_rp_q + RX_PW'(1);
    if (tx_push) tx_wp_d = (tx_wp_q == TX_LAST) ? '0 : tx_wp_q + TX_PW'(1);
    if (tx_pop)  tx_rp_d = (tx_rp_q == TX_LAST) ? '0 : tx_rp_q + TX_PW'(1);
    if (rx_clr) begin
      rx_wp_d = '0;
      rx_rp_d = '0;
    end
    if (tx_clr) begin
      tx_wp_d = '0;
      tx_rp_d = '0;
    end
  end

  // FIFO data words are filled in from the memories when the response is loaded.
  always_comb begin
    rsp_d.read_data     = rd_data;
    rsp_d.tx_valid      = tx_pop;
    rsp_d.tx_byte       = 8'h00;
    rsp_d.irq_pending   = irq_post.pending;
    rsp_d.int_id        = irq_post.id;
    rsp_d.rx_full       = rx_full_d;
    rsp_d.dtr_out       = mcr_d[0];
    rsp_d.rts_out       = mcr_d[1];
    rsp_d.baud_divisor  = {dlm_d, dll_d};
    rsp_d.char_bits     = CHAR_BITS_MIN + {2'b00, lcr_d[1:0]};
    rsp_d.parity_enable = lcr_d[3];
    rsp_d.parity_odd    = !lcr_d[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q     <= '0;
      rx_rp_q     <= '0;
      tx_wp_q     <= '0;
      tx_rp_q     <= '0;
      lcr_q       <= '0;
      mcr_q       <= '0;
      ier_q       <= '0;
      fcr_q       <= '0;
      lvl_q       <= '0;
      dlt_q       <= '0;
      dll_q       <= '0;
      dlm_q       <= '0;
      scr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        rx_wp_q <= rx_wp_d;
        rx_rp_q <= rx_rp_d;
        tx_wp_q <= tx_wp_d;
        tx_rp_q <= tx_rp_d;
        lcr_q   <= lcr_d;
        mcr_q   <= mcr_d;
        ier_q   <= ier_d;
        fcr_q   <= fcr_d;
        lvl_q   <= lvl_d;
        dlt_q   <= dlt_d;
        dll_q   <= dll_d;
        dlm_q   <= dlm_d;
        scr_q   <= scr_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_t rsp_load;
    rsp_load = rsp_d;
    if (rx_pop) rsp_load.read_data = rx_mem[rx_rslot];
    if (tx_pop) rsp_load.tx_byte = tx_mem[tx_rslot];
    if (in_accept) begin
      rsp_q <= rsp_load;
      if (rx_push) rx_mem[rx_wslot] <= req_i.payload.rx_byte;
      if (tx_push) tx_mem[tx_wslot] <= req_i.payload.write_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/urb_chk.sv
// Port-level checks for the UART register block and the bind that attaches them.
// Depends on urb_pkg and on the top level uart_register_block_with_fifos.
`default_nettype none

module urb_chk
  import urb_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  req_valid_i,
  input wire  req_ready_i,
  input req_t req_payload_i,
  input wire  rsp_valid_i,
  input wire  rsp_ready_i,
  input rsp_t rsp_payload_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // A stalled response holds its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response changed while stalled");

  // Only a bus read returns register data.
  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_payload_i.mode != MODE_READ) |=> rsp_valid_i && (rsp_payload_i.read_data == 8'h00))
    else $error("read data set on a request that is not a read");

  // No transmit byte without a transmit handoff.
  a_tx_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.tx_valid |-> rsp_payload_i.tx_byte == 8'h00)
    else $error("transmit byte without transmit valid");

  // A modem control write shows on the modem outputs of its own response.
  a_mcr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_payload_i.mode == MODE_WRITE) && (req_payload_i.reg_addr == ADDR_MCR)
    |=> rsp_valid_i && (rsp_payload_i.dtr_out == $past(req_payload_i.write_data[0]))
        && (rsp_payload_i.rts_out == $past(req_payload_i.write_data[1])))
    else $error("modem control write not reflected on dtr and rts");

  // No interrupt pending means an identifier of zero.
  a_idle_int_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.irq_pending |-> rsp_payload_i.int_id == INT_ID_MODEM)
    else $error("interrupt identifier set without a pending interrupt");

endmodule

bind uart_register_block_with_fifos urb_chk u_urb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_payload_i (req_i.payload),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

`default_nettype wire
